>>> src/sdcr_pkg.sv
`default_nettype none

package sdcr_pkg;

    localparam logic [31:0] CMD_FIRST         = 32'h4241_524D;
    localparam logic [31:0] CMD_SECOND        = 32'h4250_5043;
    localparam logic [31:0] RESET_MAX_LENGTH  = 32'd20971520;
    localparam logic [31:0] RESET_TIMEOUT     = 32'd5000;
    localparam logic [31:0] RESET_BASE_ARM    = 32'h0000_0000;
    localparam logic [31:0] RESET_BASE_PPC    = 32'h1010_0000;
    localparam logic [31:0] LENGTH_BYTES      = 32'd4;
    localparam int          CFG_INDEX_WIDTH   = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ENABLE     = 3'd0,
        REG_MAX_LENGTH = 3'd1,
        REG_TIMEOUT    = 3'd2,
        REG_BASE_ARM   = 3'd3,
        REG_BASE_PPC   = 3'd4
    } sdcr_reg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } sdcr_phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_COMMAND = 3'd1,
        EV_START   = 3'd2,
        EV_DONE    = 3'd3,
        EV_TOOBIG  = 3'd4,
        EV_TIMEOUT = 3'd5
    } sdcr_event_t;

    typedef struct packed {
        logic        enable;
        logic [31:0] max_length;
        logic [31:0] timeout_ticks;
        logic [31:0] base_arm;
        logic [31:0] base_ppc;
    } sdcr_cfg_t;

    typedef struct packed {
        sdcr_event_t event_res;
        logic        target;
        logic        write_valid;
        logic [31:0] write_address;
        logic [7:0]  write_data;
    } sdcr_result_t;

endpackage

`default_nettype wire

>>> src/sdcr_cfg_regs.sv
`default_nettype none

module sdcr_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [sdcr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [31:0]                         cfg_data,
    output sdcr_pkg::sdcr_cfg_t                      cfg
);
    import sdcr_pkg::*;

    sdcr_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable        <= 1'b1;
            cfg_reg.max_length    <= RESET_MAX_LENGTH;
            cfg_reg.timeout_ticks <= RESET_TIMEOUT;
            cfg_reg.base_arm      <= RESET_BASE_ARM;
            cfg_reg.base_ppc      <= RESET_BASE_PPC;
        end else if (cfg_valid) begin
            unique case (sdcr_reg_index_t'(cfg_index))
                REG_ENABLE:     cfg_reg.enable        <= cfg_data[0];
                REG_MAX_LENGTH: cfg_reg.max_length    <= cfg_data;
                REG_TIMEOUT:    cfg_reg.timeout_ticks <= cfg_data;
                REG_BASE_ARM:   cfg_reg.base_arm      <= cfg_data;
                REG_BASE_PPC:   cfg_reg.base_ppc      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/sdcr_core.sv
`default_nettype none

module sdcr_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic              item_func,
    input  wire logic [7:0]        item_byte,
    input  wire sdcr_pkg::sdcr_cfg_t cfg,
    output sdcr_pkg::sdcr_result_t result
);
    import sdcr_pkg::*;

    sdcr_phase_t phase_reg, phase_next;
    logic [31:0] command_word_reg, command_word_next;
    logic [31:0] length_word_reg, length_word_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] next_address_reg, next_address_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        timing_active_reg, timing_active_next;
    logic        active_target_reg, active_target_next;

    logic [31:0] elapsed_inc;
    logic [31:0] length_shift;
    logic [31:0] command_shift;
    logic [31:0] bytes_left_dec;

    assign elapsed_inc = (item_func && timing_active_reg && (elapsed_reg != '1))
                         ? elapsed_reg + 32'd1 : elapsed_reg;
    assign length_shift   = {length_word_reg[23:0], item_byte};
    assign command_shift  = {command_word_reg[23:0], item_byte};
    assign bytes_left_dec = bytes_left_reg - 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            command_word_reg  <= '0;
            length_word_reg   <= '0;
            bytes_left_reg    <= '0;
            next_address_reg  <= '0;
            elapsed_reg       <= '0;
            timing_active_reg <= 1'b0;
            active_target_reg <= 1'b0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            command_word_reg  <= command_word_next;
            length_word_reg   <= length_word_next;
            bytes_left_reg    <= bytes_left_next;
            next_address_reg  <= next_address_next;
            elapsed_reg       <= elapsed_next;
            timing_active_reg <= timing_active_next;
            active_target_reg <= active_target_next;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        command_word_next  = command_word_reg;
        length_word_next   = length_word_reg;
        bytes_left_next    = bytes_left_reg;
        next_address_next  = next_address_reg;
        elapsed_next       = elapsed_reg;
        timing_active_next = timing_active_reg;
        active_target_next = active_target_reg;
        result             = '0;

        if (cfg.enable) begin
            elapsed_next = elapsed_inc;
            if (timing_active_reg && (elapsed_inc > cfg.timeout_ticks)) begin
                result.event_res   = EV_TIMEOUT;
                result.target      = active_target_reg;
                command_word_next  = '0;
                timing_active_next = 1'b0;
                elapsed_next       = '0;
                phase_next         = PH_IDLE;
            end else if (!item_func) begin
                unique case (phase_reg)
                    PH_LENGTH: begin
                        length_word_next = length_shift;
                        bytes_left_next  = bytes_left_dec;
                        if (bytes_left_dec == '0) begin
                            result.target = active_target_reg;
                            if (length_shift > cfg.max_length) begin
                                result.event_res   = EV_TOOBIG;
                                command_word_next  = '0;
                                timing_active_next = 1'b0;
                                elapsed_next       = '0;
                                phase_next         = PH_IDLE;
                            end else if (length_shift == '0) begin
                                result.event_res   = EV_DONE;
                                command_word_next  = '0;
                                timing_active_next = 1'b0;
                                elapsed_next       = '0;
                                phase_next         = PH_IDLE;
                            end else begin
                                result.event_res = EV_START;
                                phase_next       = PH_PAYLOAD;
                                bytes_left_next  = length_shift;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        result.write_valid   = 1'b1;
                        result.write_address = next_address_reg;
                        result.write_data    = item_byte;
                        result.target        = active_target_reg;
                        next_address_next    = next_address_reg + 32'd1;
                        bytes_left_next      = bytes_left_dec;
                        if (bytes_left_dec == '0) begin
                            result.event_res   = EV_DONE;
                            command_word_next  = '0;
                            timing_active_next = 1'b0;
                            elapsed_next       = '0;
                            phase_next         = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next        = PH_IDLE;
                        command_word_next = command_shift;
                        if (command_shift == CMD_FIRST
                                || command_shift == CMD_SECOND) begin
                            phase_next         = PH_LENGTH;
                            length_word_next   = '0;
                            bytes_left_next    = LENGTH_BYTES;
                            timing_active_next = 1'b1;
                            elapsed_next       = '0;
                            result.event_res   = EV_COMMAND;
                            if (command_shift == CMD_FIRST) begin
                                next_address_next  = cfg.base_arm;
                                active_target_next = 1'b0;
                                result.target      = 1'b0;
                            end else begin
                                next_address_next  = cfg.base_ppc;
                                active_target_next = 1'b1;
                                result.target      = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> src/serial_download_command_receiver.sv
// Receives a stream of items, each a serial byte or a timer tick, finds one of two
// download commands, collects a big-endian 32-bit length and turns the payload bytes
// into writes at consecutive addresses, giving exactly one result item per input item.
// An item is taken into an input register and, once the output register is free,
// resolved against the state into it, so one item is accepted every cycle when the
// result side keeps up. Configuration writes are always accepted and must be made
// only while no item is in flight.
`default_nettype none

module serial_download_command_receiver (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_func,
    input  wire logic [7:0]                          s_rx_byte,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [2:0]                               m_event_res,
    output logic                                     m_target,
    output logic                                     m_write_valid,
    output logic [31:0]                              m_write_address,
    output logic [7:0]                               m_write_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sdcr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [31:0]                         cfg_data
);
    import sdcr_pkg::*;

    sdcr_cfg_t    cfg;
    sdcr_result_t result;
    sdcr_result_t out_reg;
    logic         in_valid_reg;
    logic         in_func_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    logic         advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    sdcr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdcr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item_func (in_func_reg),
        .item_byte (in_byte_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_event_res     = out_reg.event_res;
    assign m_target        = out_reg.target;
    assign m_write_valid   = out_reg.write_valid;
    assign m_write_address = out_reg.write_address;
    assign m_write_data    = out_reg.write_data;

endmodule

`default_nettype wire
